### rtl/brs_pkg.sv
// brs_pkg: shared types, codes and helpers for the byte ring stream with seek
// used by brs_cfg, brs_ctrl, brs_checker and the top level; no dependencies
package brs_pkg;

  localparam int DEF_STORE_DEPTH = 1024;
  localparam int CNT_W           = 11;
  localparam int OFF_W           = 13;
  localparam int PADDR_W         = 3;

  localparam logic [CNT_W-1:0] RING_SIZE_RST = 11'd1024;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_SEEK  = 2'd2;

  // seek origin codes
  localparam logic [1:0] WH_BEGIN = 2'd0;
  localparam logic [1:0] WH_CUR   = 2'd1;
  localparam logic [1:0] WH_END   = 2'd2;
  localparam logic [1:0] WH_BAD   = 2'd3;

  // initial mode codes; the unused code behaves as empty
  localparam logic [1:0] MODE_AUTO  = 2'd0;
  localparam logic [1:0] MODE_FULL  = 2'd1;
  localparam logic [1:0] MODE_EMPTY = 2'd2;

  // register indexes
  localparam logic REG_RING_SIZE = 1'b0;
  localparam logic REG_INIT_MODE = 1'b1;

  localparam logic [1:0] MODE_RST = MODE_AUTO;

  typedef struct packed {
    logic             reinit;
    logic [CNT_W-1:0] eff_size;
    logic [1:0]       mode;
  } cfg_t;

  typedef struct packed {
    logic             got;
    logic             eod;
    logic             rej;
    logic [CNT_W-1:0] level;
    logic             valid;
  } res_t;

  // ring size clamped to 1..depth
  function automatic logic [CNT_W-1:0] eff_size_f(input logic [CNT_W-1:0] ring,
                                                  input int depth);
    logic [CNT_W-1:0] sz;
    if (ring == '0) begin
      sz = CNT_W'(1);
    end else if (int'(ring) > depth) begin
      sz = CNT_W'(depth);
    end else begin
      sz = ring;
    end
    return sz;
  endfunction

endpackage

### rtl/brs_store.sv
// brs_store: byte memory, one write port and one registered read port
// depends on nothing; depth from the top level parameter
module brs_store #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(STORE_DEPTH)-1:0] waddr,
  input  logic [7:0]                     wdata,
  input  logic                           re,
  input  logic [$clog2(STORE_DEPTH)-1:0] raddr,
  output logic [7:0]                     rdata
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/brs_cfg.sv
// brs_cfg: apb register file for ring size and initial mode
// depends on brs_pkg; flags a stream reinit on every write
module brs_cfg
  import brs_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [CNT_W-1:0] ring_r, ring_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic             wr;
  logic             idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[2];

  always_comb begin
    ring_nxt = ring_r;
    mode_nxt = mode_r;
    if (wr) begin
      case (idx)
        REG_RING_SIZE: ring_nxt = pwdata[CNT_W-1:0];
        REG_INIT_MODE: mode_nxt = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r <= RING_SIZE_RST;
      mode_r <= MODE_RST;
    end else begin
      ring_r <= ring_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_RING_SIZE: prdata = 32'(ring_r);
      REG_INIT_MODE: prdata = 32'(mode_r);
      default:       prdata = '0;
    endcase
  end

  // new values go out in the write cycle so the reinit sees them
  assign cfg.reinit   = wr;
  assign cfg.eff_size = eff_size_f(ring_nxt, STORE_DEPTH);
  assign cfg.mode     = mode_nxt;

endmodule

### rtl/brs_ctrl.sv
// brs_ctrl: cursors, valid count and init flag; decodes each word and drives
// the store ports; depends on brs_pkg
module brs_ctrl
  import brs_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           accept,
  input  logic [1:0]                     req_type,
  input  logic [7:0]                     wr_data,
  input  logic signed [OFF_W-1:0]        seek_offset,
  input  logic [1:0]                     seek_whence,
  output logic                           mem_we,
  output logic [$clog2(STORE_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                     mem_wdata,
  output logic [$clog2(STORE_DEPTH)-1:0] mem_raddr,
  output res_t                           res
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = (AW < CNT_W) ? AW : CNT_W;
  localparam int SW = CNT_W + 4;
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  logic [CW-1:0]    rd_pos_r, rd_pos_nxt;
  logic [CW-1:0]    wr_pos_r, wr_pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             uninit_r, uninit_nxt;

  logic [CNT_W-1:0] size;
  logic signed [SW-1:0] r_s, w_s, size_s, off_s;

  // write path
  logic [CNT_W-1:0]     wr_cnt, wr_cnt_new, w_inc;
  logic                 wr_full, wr_wrap;
  logic signed [SW-1:0] wr_cnt_s, wr_flat, wr_grown;
  logic [CW-1:0]        w_next;

  // read path
  logic [CNT_W-1:0] rd_cnt, r_inc;
  logic             rd_empty;
  logic [CW-1:0]    r_next;

  // seek path
  logic signed [SW-1:0] cur_s, end_s, target, nvalid, sk_pos;
  logic                 sk_rej;

  assign size   = cfg.eff_size;
  assign r_s    = $signed(SW'(rd_pos_r));
  assign w_s    = $signed(SW'(wr_pos_r));
  assign size_s = $signed(SW'(size));
  assign off_s  = SW'(seek_offset);

  // a write on an uninitialized stream starts from empty
  assign wr_cnt     = uninit_r ? '0 : cnt_r;
  assign wr_full    = wr_cnt >= size;
  assign wr_cnt_s   = $signed(SW'(wr_cnt));
  assign wr_wrap    = (r_s + wr_cnt_s) >= size_s;
  assign wr_flat    = (wr_wrap && (w_s < r_s)) ? (w_s + size_s) : w_s;
  assign wr_grown   = wr_flat + ONE_S - r_s;
  assign wr_cnt_new = (wr_grown > wr_cnt_s) ? CNT_W'(wr_grown) : wr_cnt;
  assign w_inc      = CNT_W'(wr_pos_r) + CNT_W'(1);
  assign w_next     = (w_inc == size) ? '0 : CW'(w_inc);

  // a read on an uninitialized stream starts from full
  assign rd_cnt   = uninit_r ? size : cnt_r;
  assign rd_empty = (rd_cnt == '0);
  assign r_inc    = CNT_W'(rd_pos_r) + CNT_W'(1);
  assign r_next   = (r_inc == size) ? '0 : CW'(r_inc);

  assign cur_s = (r_s > w_s) ? r_s : w_s;
  assign end_s = r_s + $signed(SW'(cnt_r));

  always_comb begin
    case (seek_whence)
      WH_BEGIN: target = off_s;
      WH_CUR:   target = cur_s + off_s;
      default:  target = end_s + off_s;
    endcase
  end

  assign nvalid = end_s - target;
  assign sk_rej = uninit_r || (seek_whence == WH_BAD) || target[SW-1] ||
                  nvalid[SW-1] || (nvalid > size_s);
  // target stays below twice the size once accepted
  assign sk_pos = (target >= size_s) ? (target - size_s) : target;

  always_comb begin
    rd_pos_nxt = rd_pos_r;
    wr_pos_nxt = wr_pos_r;
    cnt_nxt    = cnt_r;
    uninit_nxt = uninit_r;
    res.got    = 1'b0;
    res.eod    = 1'b0;
    res.rej    = 1'b0;
    case (req_type)
      REQ_WRITE: begin
        uninit_nxt = 1'b0;
        cnt_nxt    = wr_cnt;
        if (wr_full) begin
          res.rej = 1'b1;
        end else begin
          cnt_nxt    = wr_cnt_new;
          wr_pos_nxt = w_next;
        end
      end
      REQ_READ: begin
        uninit_nxt = 1'b0;
        cnt_nxt    = rd_cnt;
        if (rd_empty) begin
          uninit_nxt = 1'b1;
          res.eod    = 1'b1;
        end else begin
          res.got    = 1'b1;
          rd_pos_nxt = r_next;
          cnt_nxt    = rd_cnt - CNT_W'(1);
        end
      end
      REQ_SEEK: begin
        if (sk_rej) begin
          res.rej = 1'b1;
        end else begin
          cnt_nxt    = CNT_W'(nvalid);
          rd_pos_nxt = CW'(sk_pos);
          wr_pos_nxt = CW'(sk_pos);
        end
      end
      default: ;
    endcase
    res.level = uninit_nxt ? '0 : cnt_nxt;
    res.valid = ~uninit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r <= '0;
      wr_pos_r <= '0;
      cnt_r    <= '0;
      uninit_r <= 1'b1;
    end else if (cfg.reinit) begin
      rd_pos_r <= '0;
      wr_pos_r <= '0;
      uninit_r <= (cfg.mode == MODE_AUTO);
      cnt_r    <= (cfg.mode == MODE_FULL) ? cfg.eff_size : '0;
    end else if (accept) begin
      rd_pos_r <= rd_pos_nxt;
      wr_pos_r <= wr_pos_nxt;
      cnt_r    <= cnt_nxt;
      uninit_r <= uninit_nxt;
    end
  end

  assign mem_we    = accept && (req_type == REQ_WRITE) && !wr_full;
  assign mem_waddr = AW'(wr_pos_r);
  assign mem_wdata = wr_data;
  assign mem_raddr = AW'(rd_pos_r);

endmodule

### rtl/byte_ring_stream_with_seek.sv
// byte_ring_stream_with_seek: circular byte store with read/write cursors and seek
// uses brs_pkg, brs_cfg, brs_ctrl and brs_store
//
// input channel: in_valid / in_stall carry one word per request: write a byte,
// read a byte or seek. result channel: out_valid / out_stall return exactly one
// word per request with the byte read, status flags, level and stream_valid.
// apb port: ring size at 0x0, initial mode at 0x4; any write restarts the
// stream (cursors zero, count and init flag per mode); write only while idle.
// an accepted word goes through the store read and internal stage, then the
// output register to the out ports. throughput: one word per cycle while
// in_stall is low; each word reads the store once, a write also uses the
// write port, and the cursors update in the cycle it is accepted.
// reset: ring size 1024, mode auto, cursors zero, stream uninitialized; the
// byte store is not cleared and holds garbage until written.
// when out_stall is high the output word holds; one more word can sit in the
// internal stage, after that in_stall rises until the result side drains.
module byte_ring_stream_with_seek
  import brs_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_req_type,
  input  logic [7:0]              in_wr_data,
  input  logic signed [OFF_W-1:0] in_seek_offset,
  input  logic [1:0]              in_seek_whence,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_rd_data,
  output logic                    out_got_byte,
  output logic                    out_end_of_data,
  output logic                    out_rejected,
  output logic [CNT_W-1:0]        out_level,
  output logic                    out_stream_valid,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int AW = $clog2(STORE_DEPTH);

  cfg_t          cfg;
  res_t          res;
  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic          s1_v_r, s1_v_nxt;
  res_t          s1_res_r;
  logic          s1_adv;
  logic          out_v_r, out_v_nxt;
  res_t          out_res_r;
  logic [7:0]    out_data_r;

  brs_cfg #(.STORE_DEPTH(STORE_DEPTH)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brs_ctrl #(.STORE_DEPTH(STORE_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .accept      (accept),
    .req_type    (in_req_type),
    .wr_data     (in_wr_data),
    .seek_offset (in_seek_offset),
    .seek_whence (in_seek_whence),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .res         (res)
  );

  // every accepted word reads the byte under the read cursor
  brs_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign s1_adv    = s1_v_r & (~out_v_r | ~out_stall);
  assign in_stall  = s1_v_r & ~s1_adv;
  assign accept    = in_valid & ~in_stall;
  assign s1_v_nxt  = accept | (s1_v_r & ~s1_adv);
  assign out_v_nxt = s1_adv | (out_v_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
    if (s1_adv) begin
      out_res_r  <= s1_res_r;
      out_data_r <= s1_res_r.got ? mem_rdata : 8'd0;
    end
  end

  assign out_valid        = out_v_r;
  assign out_rd_data      = out_data_r;
  assign out_got_byte     = out_res_r.got;
  assign out_end_of_data  = out_res_r.eod;
  assign out_rejected     = out_res_r.rej;
  assign out_level        = out_res_r.level;
  assign out_stream_valid = out_res_r.valid;

endmodule

### rtl/brs_checker.sv
// brs_checker: port-level assertions for the byte ring stream with seek
// depends on brs_pkg; bound to the top level below
module brs_checker
  import brs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       out_rd_data,
  input logic             out_got_byte,
  input logic             out_end_of_data,
  input logic             out_rejected,
  input logic [CNT_W-1:0] out_level,
  input logic             out_stream_valid
);

  // a returned byte excludes the failure flags
  a_got_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_got_byte) |-> (!out_end_of_data && !out_rejected))
    else $error("got_byte with end_of_data or rejected");

  // end of data drops the stream back to uninitialized
  a_eod_uninit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_data) |-> (!out_stream_valid && out_level == '0))
    else $error("end_of_data with stream still valid");

  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stream_valid) |-> (out_level == '0))
    else $error("nonzero level on uninitialized stream");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_got_byte) |-> (out_rd_data == 8'd0))
    else $error("rd_data nonzero without a byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_level) &&
                                  $stable(out_rd_data)))
    else $error("stalled word changed");

endmodule

bind byte_ring_stream_with_seek brs_checker u_brs_checker (.*);
